// File: rtl/core/prf_pkg.sv
package prf_pkg;

   // Default width of the number being factored and of each factor.
   localparam int NUMBER_WIDTH_DEFAULT = 31;

   // The first odd trial divisor and the step between trial divisors.
   localparam int FIRST_ODD_DIVISOR = 3;
   localparam int DIVISOR_STEP      = 2;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_stat_type;

endpackage

// File: rtl/core/prf_divider.sv
module prf_divider #(
   parameter int NUMBER_WIDTH = prf_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  prf_pkg::div_ctrl_type     ctrl,
   input  logic [NUMBER_WIDTH-1:0]   dividend,
   input  logic [NUMBER_WIDTH-1:0]   divisor,
   output prf_pkg::div_stat_type     stat,
   output logic [NUMBER_WIDTH-1:0]   quotient,
   output logic [NUMBER_WIDTH-1:0]   remainder
);

   // Restoring division, one quotient bit per cycle, most significant first.
   localparam int CW = $clog2(NUMBER_WIDTH);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] dsr_ff, dsr_in;
   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   diff;
   logic                    fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUMBER_WIDTH - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
         quo_in = {quo_ff[NUMBER_WIDTH-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.done = done_ff;
   assign stat.busy = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/prime_factorizer_core.sv
// Trial-division prime factoriser.
//
// A number is offered on req_number with start high; it is taken at a rising
// edge where start is high and busy is low. The block then emits the prime
// factors of that number in ascending order, repeats included, one word per
// factor. Each result word is shown on rsp_factor, rsp_last and rsp_none for
// exactly one cycle, marked by rsp_valid; the receiver cannot stall it, so
// every word must be captured in the cycle it appears. rsp_last marks the
// final word of a number. A number below two gives a single word with a zero
// factor and both rsp_last and rsp_none set, in the cycle after it is taken.
// Factors of two leave at one per cycle. Each odd trial divisor costs one
// pass of the shared restoring divider, and so does each factor divided
// out. For a large prime near 2^31 about 23 000 odd divisors are tried;
// that divider is what sets the rate. One word is held back so that the
// last flag can be set; it leaves from S_FLUSH at the end. busy is high
// from acceptance of a number of two or more until the final word appears.
// A synchronous reset returns the sequencer to idle and drops any work.
module prime_factorizer_core #(
   parameter int NUMBER_WIDTH = prf_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   output logic [NUMBER_WIDTH-1:0] rsp_factor,
   output logic                    rsp_last,
   output logic                    rsp_none
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_TWOS      = 3'd1;
   localparam logic [2:0] S_DIV_START = 3'd2;
   localparam logic [2:0] S_DIV_WAIT  = 3'd3;
   localparam logic [2:0] S_TAIL      = 3'd4;
   localparam logic [2:0] S_FLUSH     = 3'd5;

   localparam logic [NUMBER_WIDTH-1:0] TWO = NUMBER_WIDTH'(2);
   localparam logic [NUMBER_WIDTH-1:0] FIRST_DIV =
      NUMBER_WIDTH'(prf_pkg::FIRST_ODD_DIVISOR);
   localparam logic [NUMBER_WIDTH-1:0] DIV_STEP =
      NUMBER_WIDTH'(prf_pkg::DIVISOR_STEP);

   logic [2:0]              state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] div_ff, div_in;
   logic                    check_ff, check_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [NUMBER_WIDTH-1:0] pend_factor_ff, pend_factor_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_WIDTH-1:0] rsp_factor_ff, rsp_factor_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_none_ff, rsp_none_in;

   logic                    new_factor;
   logic [NUMBER_WIDTH-1:0] new_value;

   prf_pkg::div_ctrl_type   div_ctrl;
   prf_pkg::div_stat_type   div_stat;
   logic [NUMBER_WIDTH-1:0] div_quot;
   logic [NUMBER_WIDTH-1:0] div_rem;

   // The one shared arithmetic unit: rem_ff divided by div_ff gives both the
   // divisibility test and the bound test divisor <= remainder / divisor.
   prf_divider #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (rem_ff),
      .divisor   (div_ff),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      check_in       = check_ff;
      pend_valid_in  = pend_valid_ff;
      pend_factor_in = pend_factor_ff;
      rsp_valid_in   = 1'b0;
      rsp_factor_in  = rsp_factor_ff;
      rsp_last_in    = 1'b0;
      rsp_none_in    = 1'b0;
      new_factor     = 1'b0;
      new_value      = TWO;
      div_ctrl.start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rem_in        = req_number;
               pend_valid_in = 1'b0;
               if (req_number < TWO) begin
                  // Zero and one have no prime factors: one flagged word.
                  rsp_valid_in  = 1'b1;
                  rsp_factor_in = '0;
                  rsp_last_in   = 1'b1;
                  rsp_none_in   = 1'b1;
               end else begin
                  state_in = S_TWOS;
               end
            end
         end
         S_TWOS: begin
            if (!rem_ff[0]) begin
               new_factor = 1'b1;
               new_value  = TWO;
               rem_in     = rem_ff >> 1;
            end else begin
               div_in   = FIRST_DIV;
               check_in = 1'b1;
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_ctrl.start = 1'b1;
            state_in       = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               if (check_ff && (div_ff > div_quot)) begin
                  // The divisor squared now exceeds the remainder.
                  state_in = S_TAIL;
               end else if (div_rem == '0) begin
                  // Divide this factor out and try the same divisor again.
                  new_factor = 1'b1;
                  new_value  = div_ff;
                  rem_in     = div_quot;
                  check_in   = 1'b0;
                  state_in   = S_DIV_START;
               end else begin
                  div_in   = div_ff + DIV_STEP;
                  check_in = 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_TAIL: begin
            if (rem_ff > TWO) begin
               new_factor = 1'b1;
               new_value  = rem_ff;
            end
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = pend_factor_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new factor pushes the held one out, so the final word can carry
      // the last flag once the sequencer knows no more will follow.
      if (new_factor) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = pend_factor_ff;
         end
         pend_valid_in  = 1'b1;
         pend_factor_in = new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         check_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_none_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         check_ff      <= check_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_none_ff   <= rsp_none_in;
      end
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      pend_factor_ff <= pend_factor_in;
      rsp_factor_ff  <= rsp_factor_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_none   = rsp_none_ff;

   // A word with no factors is always the only, and so the last, word.
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none |-> rsp_last && (rsp_factor == '0))
      else $error("word without factors not marked last or nonzero");

   // The final flush always has a held factor to emit.
   a_flush_has_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> pend_valid_ff)
      else $error("flush with no held factor");

   // A real factor is never below two.
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_none |-> (rsp_factor >= TWO))
      else $error("emitted factor below two");

   // The divider is only started while idle, and only waited on while busy.
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_WAIT) && !div_stat.done |-> div_stat.busy)
      else $error("waiting on an idle divider");

endmodule
